// File: rtl/pcv_pkg.sv
// Shared types, constants and the ones' complement add for the packet checksum verifier.
package pcv_pkg;

  // Widths of the item fields and of the internal state.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned CODE_W  = 2;
  localparam int unsigned POS_W   = 11;

  // Packet layout and limits.
  localparam int unsigned MAX_PAYLOAD = 1024;
  localparam int unsigned HDR_BYTES   = 4;
  localparam logic [LEN_W-1:0] BUFFER_LIMIT_RESET = LEN_W'(1024);
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Byte positions of the header fields.
  localparam logic [POS_W-1:0] POS_SIZE_LO = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SIZE_HI = POS_W'(1);
  localparam logic [POS_W-1:0] POS_CSUM_LO = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CSUM_HI = POS_W'(3);

  // Verdict codes.
  localparam logic [CODE_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [CODE_W-1:0] STATUS_CORRUPTED = 2'd1;
  localparam logic [CODE_W-1:0] STATUS_TOO_LARGE = 2'd2;
  localparam logic [CODE_W-1:0] STATUS_MALFORMED = 2'd3;

  // Reply codes.
  localparam logic [CODE_W-1:0] REPLY_NONE = 2'd0;
  localparam logic [CODE_W-1:0] REPLY_ACK  = 2'd1;
  localparam logic [CODE_W-1:0] REPLY_NAK  = 2'd2;

  // One received byte.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  // One verdict.
  typedef struct packed {
    logic [CODE_W-1:0] status;
    logic [LEN_W-1:0]  payload_length;
    logic [CODE_W-1:0] reply;
    logic [WORD_W-1:0] computed_checksum;
  } out_item_t;

  // What the accumulator hands to the verdict logic for the current byte.
  typedef struct packed {
    logic [WORD_W-1:0] folded_sum;
    logic [WORD_W-1:0] declared_size;
    logic [WORD_W-1:0] received_checksum;
  } pkt_sum_t;

  // 16-bit ones' complement add with end-around carry.
  function automatic logic [WORD_W-1:0] add_fold(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
  endfunction

endpackage

// File: rtl/pcv_accum.sv
// Per-packet state: header capture and running ones' complement sum.
module pcv_accum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  pcv_pkg::in_item_t item,
  output pcv_pkg::pkt_sum_t summary
);
  import pcv_pkg::*;

  logic [POS_W-1:0]  pos_r,  pos_nxt;
  logic [WORD_W-1:0] sum_r,  sum_nxt;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic [WORD_W-1:0] size_r, size_nxt;
  logic [WORD_W-1:0] rcv_r,  rcv_nxt;
  logic              counted;
  logic              is_csum_byte;
  logic [BYTE_W-1:0] v;

  // Next state for the byte now leaving the input register.
  always_comb begin
    counted      = (pos_r < POS_CSUM_LO) || ({{(WORD_W-POS_W){1'b0}}, pos_r} < size_r);
    is_csum_byte = (pos_r == POS_CSUM_LO) || (pos_r == POS_CSUM_HI);
    v            = is_csum_byte ? '0 : item.data_byte;
    size_nxt     = size_r;
    rcv_nxt      = rcv_r;
    sum_nxt      = sum_r;
    held_nxt     = held_r;

    // Header fields are little-endian.
    case (pos_r)
      POS_SIZE_LO: size_nxt = {size_r[WORD_W-1:BYTE_W], item.data_byte};
      POS_SIZE_HI: size_nxt = {item.data_byte, size_r[BYTE_W-1:0]};
      POS_CSUM_LO: rcv_nxt  = {rcv_r[WORD_W-1:BYTE_W], item.data_byte};
      POS_CSUM_HI: rcv_nxt  = {item.data_byte, rcv_r[BYTE_W-1:0]};
      default: ;
    endcase

    // Even bytes are held as the low half; odd bytes complete the word.
    if (counted) begin
      if (!pos_r[0]) begin
        held_nxt = v;
      end else begin
        sum_nxt  = add_fold(sum_r, {v, held_r});
        held_nxt = '0;
      end
    end

    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
  end

  // Summary including a pending odd byte padded with zero.
  assign summary.folded_sum        = add_fold(sum_nxt, {{(WORD_W-BYTE_W){1'b0}}, held_nxt});
  assign summary.declared_size     = size_nxt;
  assign summary.received_checksum = rcv_nxt;

  // State update; the last byte clears everything for the next packet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      held_r <= '0;
      size_r <= '0;
      rcv_r  <= '0;
    end else if (step) begin
      if (item.last_byte) begin
        pos_r  <= '0;
        sum_r  <= '0;
        held_r <= '0;
        size_r <= '0;
        rcv_r  <= '0;
      end else begin
        pos_r  <= pos_nxt;
        sum_r  <= sum_nxt;
        held_r <= held_nxt;
        size_r <= size_nxt;
        rcv_r  <= rcv_nxt;
      end
    end
  end

endmodule

// File: rtl/pcv_verdict.sv
// Verdict logic: size check, checksum compare and buffer limit check.
module pcv_verdict (
  input  pcv_pkg::pkt_sum_t            summary,
  input  logic [pcv_pkg::LEN_W-1:0]    buffer_limit,
  output pcv_pkg::out_item_t           verdict
);
  import pcv_pkg::*;

  localparam logic [WORD_W:0]   MaxSize = (WORD_W+1)'(MAX_PAYLOAD + HDR_BYTES);
  localparam logic [WORD_W-1:0] HdrSize = WORD_W'(HDR_BYTES);

  logic              malformed;
  logic [WORD_W-1:0] csum;
  logic [WORD_W-1:0] plen;

  always_comb begin
    malformed = (summary.declared_size < HdrSize) ||
                ({1'b0, summary.declared_size} > MaxSize);
    csum      = ~summary.folded_sum;
    plen      = summary.declared_size - HdrSize;

    // The checksum compare takes precedence over the limit check.
    if (malformed) begin
      verdict.status            = STATUS_MALFORMED;
      verdict.payload_length    = '0;
      verdict.reply             = REPLY_NONE;
      verdict.computed_checksum = '0;
    end else begin
      verdict.payload_length    = plen[LEN_W-1:0];
      verdict.computed_checksum = csum;
      if (csum != summary.received_checksum) begin
        verdict.status = STATUS_CORRUPTED;
        verdict.reply  = REPLY_NAK;
      end else if (plen > {{(WORD_W-LEN_W){1'b0}}, buffer_limit}) begin
        verdict.status = STATUS_TOO_LARGE;
        verdict.reply  = REPLY_NONE;
      end else begin
        verdict.status = STATUS_OK;
        verdict.reply  = REPLY_ACK;
      end
    end
  end

endmodule

// File: rtl/packet_checksum_verifier_core.sv
// Top level of the packet checksum verifier: input register, accumulator, verdict register.
// Takes one packet byte per cycle, back to back, unless stalled as below; gives one verdict
// item per packet, loaded into the result register as the byte marked last leaves the input
// register. Each byte passes an input register, then the ones' complement add and the
// verdict compare, then the result register; the input side keeps taking bytes while a
// verdict waits on the output, and stalls only when a further last byte finds the result
// register occupied. buffer_limit resets to 1024; the cfg_ port writing it is always ready.
module packet_checksum_verifier_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pcv_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pcv_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcv_pkg::LEN_W-1:0]     cfg_data
);
  import pcv_pkg::*;

  in_item_t         in_item_r;
  logic             in_valid_r;
  out_item_t        out_item_r;
  logic             out_valid_r;
  logic [LEN_W-1:0] buffer_limit_r;
  logic             out_free;
  logic             advance;
  pkt_sum_t         summary;
  out_item_t        verdict;

  // A byte moves on unless it is a last byte and the result slot is full.
  assign out_free  = !out_valid_r || out_ready;
  assign advance   = in_valid_r && (!in_item_r.last_byte || out_free);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  pcv_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .item    (in_item_r),
    .summary (summary)
  );

  pcv_verdict u_verdict (
    .summary      (summary),
    .buffer_limit (buffer_limit_r),
    .verdict      (verdict)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_item_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_item_r.last_byte) begin
      out_item_r <= verdict;
    end
  end

  // Buffer limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_limit_r <= BUFFER_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      buffer_limit_r <= cfg_data;
    end
  end

endmodule
